// ----- sv/sbh_pkg.sv -----
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sbh_pkg;

	// One command word from the input queue.
	typedef struct packed {
		logic       finish;
		logic [7:0] data;
	} cmd_t;

	// One result word toward the output queue.
	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} res_t;

	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam int         BLOCK_BITS    = 512;
	localparam int         HASH_WORDS    = 8;
	localparam logic [5:0] LAST_BYTE     = 6'd63;
	localparam logic [5:0] LEN_START     = 6'd56;
	localparam logic [5:0] LAST_ROUND    = 6'd63;
	localparam logic [2:0] LAST_WORD_IDX = 3'd7;

	// Initial hash values.
	function automatic logic [31:0] init_hash(input logic [2:0] idx);
		logic [31:0] v;
		case (idx)
			3'd0:    v = 32'h6a09e667;
			3'd1:    v = 32'hbb67ae85;
			3'd2:    v = 32'h3c6ef372;
			3'd3:    v = 32'ha54ff53a;
			3'd4:    v = 32'h510e527f;
			3'd5:    v = 32'h9b05688c;
			3'd6:    v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] v;
		case (t)
			6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;
			default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

// ----- sv/sbh_front.sv -----
// ----------------------------------------------------------------------------
// sbh_front
// Input command queue: takes words from the push side, tags finish commands
// and holds them until the engine takes them.
// ----------------------------------------------------------------------------
module sbh_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          action,
	input  logic [7:0]    byte_value,
	output logic          cmd_valid,
	output sbh_pkg::cmd_t cmd,
	input  logic          cmd_take
);
	import sbh_pkg::*;

	localparam int DEPTH = 2;
	localparam int AW    = $clog2(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          wr_en;
	logic          rd_en;
	cmd_t          cmd_in;

	// Classify the incoming word.
	assign cmd_in.finish = action;
	assign cmd_in.data   = byte_value;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/sbh_engine.sv -----
// ----------------------------------------------------------------------------
// sbh_engine
// Back end: collects bytes into the block window, pads the message, runs the
// 64 compression rounds one per cycle and emits the digest words.
// ----------------------------------------------------------------------------
module sbh_engine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  sbh_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic          res_push,
	output sbh_pkg::res_t res,
	input  logic          res_full
);
	import sbh_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_PAD    = 3'd1;
	localparam logic [2:0] ST_ROUND  = 3'd2;
	localparam logic [2:0] ST_UPDATE = 3'd3;
	localparam logic [2:0] ST_EMIT   = 3'd4;

	logic [2:0]   state_q;
	logic [5:0]   cnt_q;
	logic [54:0]  blocks_q;
	logic [63:0]  len_q;
	logic         first_q;
	logic         len_blk_q;
	logic         pad_q;
	logic [5:0]   round_q;
	logic [2:0]   emit_q;
	logic [511:0] win_q;
	logic [31:0]  hash_q [HASH_WORDS];
	logic [31:0]  wv_q   [HASH_WORDS];

	logic         shift_en;
	logic [7:0]   shift_byte;
	logic [7:0]   pad_byte;
	logic [2:0]   len_sel;
	logic [31:0]  w0;
	logic [31:0]  w_next;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  ch;
	logic [31:0]  mj;

	// Byte inserted while padding: marker, zeros, then the length field.
	assign len_sel  = LAST_WORD_IDX - cnt_q[2:0];
	always_comb begin
		if (first_q) begin
			pad_byte = PAD_BYTE;
		end else if (len_blk_q && (cnt_q >= LEN_START)) begin
			pad_byte = len_q[{len_sel, 3'b000} +: 8];
		end else begin
			pad_byte = 8'd0;
		end
	end

	// Byte entry into the block window.
	assign cmd_take   = (state_q == ST_IDLE) && cmd_valid;
	assign shift_en   = (cmd_take && !cmd.finish) || (state_q == ST_PAD);
	assign shift_byte = (state_q == ST_PAD) ? pad_byte : cmd.data;

	// Message schedule: the window holds W[t] .. W[t+15].
	assign w0     = win_q[511 -: 32];
	assign w_next = small_sigma1(win_q[511 - 32*14 -: 32]) + win_q[511 - 32*9 -: 32]
		+ small_sigma0(win_q[511 - 32*1 -: 32]) + w0;

	// Round function.
	assign ch = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
	assign mj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
	assign t1 = wv_q[7] + big_sigma1(wv_q[4]) + ch + round_k(round_q) + w0;
	assign t2 = big_sigma0(wv_q[0]) + mj;

	// Digest word output.
	assign res_push  = (state_q == ST_EMIT) && !res_full;
	assign res.word  = hash_q[emit_q];
	assign res.index = emit_q;
	assign res.last  = (emit_q == LAST_WORD_IDX);

	// Block window and working variables.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			win_q <= {win_q[503:0], shift_byte};
		end else if (state_q == ST_ROUND) begin
			win_q <= {win_q[479:0], w_next};
		end
		if (shift_en && (cnt_q == LAST_BYTE)) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				wv_q[i] <= hash_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			wv_q[7] <= wv_q[6];
			wv_q[6] <= wv_q[5];
			wv_q[5] <= wv_q[4];
			wv_q[4] <= wv_q[3] + t1;
			wv_q[3] <= wv_q[2];
			wv_q[2] <= wv_q[1];
			wv_q[1] <= wv_q[0];
			wv_q[0] <= t1 + t2;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			blocks_q  <= '0;
			len_q     <= '0;
			first_q   <= 1'b0;
			len_blk_q <= 1'b0;
			pad_q     <= 1'b0;
			round_q   <= '0;
			emit_q    <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				hash_q[i] <= init_hash(3'(i));
			end
		end else begin
			if (shift_en) begin
				cnt_q <= cnt_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take && cmd.finish) begin
						len_q     <= {blocks_q, cnt_q, 3'b000};
						first_q   <= 1'b1;
						len_blk_q <= (cnt_q < LEN_START);
						state_q   <= ST_PAD;
					end else if (cmd_take && (cnt_q == LAST_BYTE)) begin
						blocks_q <= blocks_q + 55'd1;
						pad_q    <= 1'b0;
						round_q  <= '0;
						state_q  <= ST_ROUND;
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (cnt_q == LAST_BYTE) begin
						pad_q   <= 1'b1;
						round_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LAST_ROUND) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						hash_q[i] <= hash_q[i] + wv_q[i];
					end
					if (!pad_q) begin
						state_q <= ST_IDLE;
					end else if (len_blk_q) begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						len_blk_q <= 1'b1;
						state_q   <= ST_PAD;
					end
				end
				ST_EMIT: begin
					if (res_push) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == LAST_WORD_IDX) begin
							blocks_q <= '0;
							for (int i = 0; i < HASH_WORDS; i++) begin
								hash_q[i] <= init_hash(3'(i));
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/sbh_result_queue.sv -----
// ----------------------------------------------------------------------------
// sbh_result_queue
// Output queue for digest words; holds a whole digest so the engine can
// return to absorbing while the consumer drains it.
// ----------------------------------------------------------------------------
module sbh_result_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	input  sbh_pkg::res_t res,
	output logic          res_full,
	output logic          empty,
	input  logic          pop,
	output logic [31:0]   digest_word,
	output logic [2:0]    word_index,
	output logic          last
);
	import sbh_pkg::*;

	localparam int DEPTH = 8;
	localparam int AW    = $clog2(DEPTH);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          wr_en;
	logic          rd_en;
	res_t          head;

	assign res_full    = (count_q == (AW+1)'(DEPTH));
	assign empty       = (count_q == '0);
	assign wr_en       = res_push && !res_full;
	assign rd_en       = pop && !empty;
	assign head        = mem_q[rd_ptr_q];
	assign digest_word = head.word;
	assign word_index  = head.index;
	assign last        = head.last;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= res;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (AW+1)'(1);
				2'b01:   count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/sha256_byte_stream_hasher.sv -----
// SHA-256 over a byte stream. Push one word per message byte (action low) and
// one finish word (action high); the eight digest words then appear on the
// result side in order, the last one flagged, and the hasher starts a new
// message. Every 64th byte starts the 64 compression rounds, at one per cycle
// in the single round unit, and then the hash update; no new byte is taken
// until that block is done. A finish pads to the end of the block (marker
// byte, zeros, then the length field, in a second padded block when 56 or
// more bytes are pending), compresses each padded block and emits the digest
// words, which wait while the result queue is full. A two-word command queue
// and an eight-word result queue decouple both sides.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// Top level: command queue, hashing engine and result queue.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  byte_value,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last
);
	import sbh_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_take;
	logic res_push;
	res_t res;
	logic res_full;

	// Command side.
	sbh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.action     (action),
		.byte_value (byte_value),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	// Hashing engine.
	sbh_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	// Result side.
	sbh_result_queue u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_push    (res_push),
		.res         (res),
		.res_full    (res_full),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (last)
	);

`ifndef NO_ASSERTIONS
	// The engine only takes a command that is present.
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid)
		else $error("engine took a command from an empty queue");

	// The engine never pushes a digest word into a full result queue.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("digest word pushed into full result queue");

	// The final flag marks exactly the eighth digest word.
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last == (word_index == LAST_WORD_IDX)))
		else $error("last flag does not match word index");

	// Digest words leave the engine in index order.
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.last) |=> (res.index == $past(res.index) + 3'd1))
		else $error("digest word index out of order");
`endif

endmodule

// ----- tb/sbh_check_pkg.sv -----
// ----------------------------------------------------------------------------
// sbh_check_pkg
// Digest predictor and result checker for the SHA-256 byte hasher bench.
// ----------------------------------------------------------------------------
package sbh_check_pkg;

	localparam bit ACT_ABSORB   = 1'b0;
	localparam bit ACT_FINISH   = 1'b1;
	localparam int REPORT_LIMIT = 10;

	// Tracks the hash state of the message in flight and queues the eight
	// digest words that each finish word must produce.
	class digest_tracker;
		bit [31:0]     chain [8];
		bit [7:0]      block [64];
		bit [5:0]      fill;
		bit [63:0]     msg_bits;
		bit [31:0]     k_table [64];
		sbh_pkg::res_t digest_words_due [$];
		int unsigned   bad_words;

		function new();
			k_table = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
			};
			bad_words = 0;
			restart();
		endfunction

		// Start a new message from the standard initial hash value.
		function void restart();
			chain = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
			fill     = 6'd0;
			msg_bits = 64'd0;
		endfunction

		function bit [31:0] rotr(bit [31:0] x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function bit [31:0] sched_lo(bit [31:0] x);
			return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
		endfunction

		function bit [31:0] sched_hi(bit [31:0] x);
			return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
		endfunction

		// One 64-round compression of the current block into the chain.
		function void compress();
			bit [31:0] w [16];
			bit [31:0] v [8];
			bit [31:0] wt, t1, t2, ch, mj;
			for (int t = 0; t < 16; t++)
				w[t] = {block[4 * t], block[4 * t + 1], block[4 * t + 2], block[4 * t + 3]};
			v = chain;
			for (int t = 0; t < 64; t++) begin
				if (t < 16) begin
					wt = w[t];
				end else begin
					wt = sched_hi(w[(t - 2) & 15]) + w[(t - 7) & 15] +
						sched_lo(w[(t - 15) & 15]) + w[t & 15];
					w[t & 15] = wt;
				end
				ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
				mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch +
					k_table[t] + wt;
				t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int i = 0; i < 8; i++)
				chain[i] += v[i];
		endfunction

		// Note one accepted input word and queue the digest it causes.
		function void take_word(sbh_pkg::cmd_t c);
			sbh_pkg::res_t r;
			int unsigned   n;
			if (c.finish == ACT_ABSORB) begin
				block[fill] = c.data;
				fill++;
				if (fill == 6'd0) begin
					compress();
					msg_bits += sbh_pkg::BLOCK_BITS;
				end
				return;
			end
			// Padding: marker byte, zeros, then the big-endian bit length.
			// A pending count that reaches the length field needs an extra block.
			n = fill;
			block[n] = sbh_pkg::PAD_BYTE;
			for (int i = n + 1; i < 64; i++)
				block[i] = 8'h00;
			if (n >= sbh_pkg::LEN_START) begin
				compress();
				block = '{default: 8'h00};
			end
			msg_bits += 64'(n) * 8;
			for (int i = 0; i < 8; i++)
				block[56 + i] = msg_bits[63 - 8 * i -: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				r.word  = chain[i];
				r.index = 3'(i);
				r.last  = (3'(i) == sbh_pkg::LAST_WORD_IDX);
				digest_words_due.push_back(r);
			end
			restart();
		endfunction

		function void flag(string msg);
			bad_words++;
			if (bad_words <= REPORT_LIMIT)
				$display("%s", msg);
		endfunction

		// Check one accepted result word against the oldest expected one.
		function void match_word(logic [31:0] word, logic [2:0] index, logic last);
			sbh_pkg::res_t want;
			if (digest_words_due.size() == 0) begin
				flag($sformatf("unexpected digest word %h index %0d last %b",
					word, index, last));
				return;
			end
			want = digest_words_due.pop_front();
			if (word !== want.word || index !== want.index || last !== want.last)
				flag($sformatf("digest word: expected %h/%0d/%b, got %h/%0d/%b",
					want.word, want.index, want.last, word, index, last));
		endfunction

		function int unsigned pending();
			return digest_words_due.size();
		endfunction

		function bit clean();
			return bad_words == 0 && digest_words_due.size() == 0;
		endfunction
	endclass

endpackage

// ----- tb/sha256_byte_stream_hasher_test.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_test
// Feeds byte messages of assorted lengths, including empty ones and ones
// that cross block boundaries or need an extra padding block, and checks
// every digest word against a software model of SHA-256. Both queue sides
// stall at random.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sbh_check_pkg::*;

	localparam int unsigned RANDOM_WORDS = 120;
	localparam int unsigned MIN_MESSAGES = 4;
	localparam int unsigned DRAIN_CYCLES = 300;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        push       = 1'b0;
	logic        action     = 1'b0;
	logic [7:0]  byte_value = 8'h00;
	logic        pop        = 1'b0;
	logic        full;
	logic        empty;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last;

	digest_tracker tracker = new();
	int unsigned   pop_run  = 0;
	int unsigned   pop_hold = 0;

	sha256_byte_stream_hasher i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.byte_value  (byte_value),
		.empty       (empty),
		.pop         (pop),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last        (last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 80);
	endfunction

	// Result side: check each accepted word, then pick the next pop value
	// from bursts of steady popping and random stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				tracker.match_word(digest_word, word_index, last);
			if (pop_run > 0) begin
				pop <= 1'b1;
				pop_run--;
			end else if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else if ($urandom_range(0, 3) == 0) begin
				pop_run = $urandom_range(20, 60);
				pop <= 1'b1;
			end else begin
				pop_hold = pick_gap();
				pop <= (pop_hold == 0);
			end
		end
	end

	// Push one word after an optional idle gap and note it once accepted.
	task automatic put_word(input bit act, input logic [7:0] value, input bit steady);
		int unsigned  idle;
		sbh_pkg::cmd_t c;
		idle = steady ? 0 : pick_gap();
		if (idle > 0) begin
			push <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		push       <= 1'b1;
		action     <= act;
		byte_value <= value;
		do @(posedge clk); while (full);
		c.finish = act;
		c.data   = value;
		tracker.take_word(c);
	endtask

	// Hold the input side until every queued digest word has been read.
	task automatic wait_drained();
		push <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	// Main stimulus: a directed opening, then random messages.
	initial begin
		int unsigned sent;
		int unsigned msgs;
		int unsigned len;
		bit          steady;
		sent = 0;
		msgs = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty message, extreme byte values, the classic three-letter
		// message, and two finishes back to back to check the restart.
		put_word(ACT_FINISH, 8'h00, 1'b0);
		put_word(ACT_ABSORB, 8'h00, 1'b0);
		put_word(ACT_ABSORB, 8'hff, 1'b0);
		put_word(ACT_FINISH, 8'hff, 1'b0);
		put_word(ACT_ABSORB, 8'h61, 1'b1);
		put_word(ACT_ABSORB, 8'h62, 1'b1);
		put_word(ACT_ABSORB, 8'h63, 1'b1);
		put_word(ACT_FINISH, 8'h5a, 1'b1);
		put_word(ACT_FINISH, 8'ha5, 1'b1);
		wait_drained();

		// Random messages: mostly short, one long enough for an extra
		// padding block and one that crosses a full block boundary.
		while (sent < RANDOM_WORDS || msgs < MIN_MESSAGES) begin
			if (msgs == 1)
				len = $urandom_range(56, 63);
			else if (msgs == 3)
				len = $urandom_range(64, 67);
			else if ($urandom_range(0, 7) == 0)
				len = $urandom_range(11, 55);
			else
				len = $urandom_range(0, 10);
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			repeat (len) put_word(ACT_ABSORB, 8'($urandom_range(0, 255)), steady);
			put_word(ACT_FINISH, 8'($urandom_range(0, 255)), steady);
			sent += len + 1;
			msgs++;
		end

		// Wait for the last digest, then watch for stray words.
		push <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.clean())
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop in case the hasher hangs.
	initial begin
		#8_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
